// ===== rtl/efws_pkg.sv =====
// Shared types and constants for the earliest-free-worker scheduler.
// Field widths, controller state encoding and the result record.
// No dependencies.
`default_nettype none

package efws_pkg;

	localparam int DURATION_W = 32;
	localparam int WORKER_W   = 6;
	localparam int START_W    = 48;
	localparam int COUNT_W    = 7;

	localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd1;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_WRITE
	} sched_state_t;

	typedef struct packed {
		logic [WORKER_W-1:0] worker;
		logic [START_W-1:0]  start_time;
	} sched_result_t;

endpackage

`default_nettype wire

// ===== rtl/efws_job_if.sv =====
// Job input channel: valid/ready handshake carrying one job duration.
// Depends on efws_pkg.
`default_nettype none

interface efws_job_if;
	import efws_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [DURATION_W-1:0] duration;

	modport source (output valid, output duration, input ready);
	modport sink (input valid, input duration, output ready);
endinterface

`default_nettype wire

// ===== rtl/efws_result_if.sv =====
// Result output channel: valid/ready handshake carrying worker and start time.
// Depends on efws_pkg.
`default_nettype none

interface efws_result_if;
	import efws_pkg::*;

	logic                valid;
	logic                ready;
	logic [WORKER_W-1:0] worker;
	logic [START_W-1:0]  start_time;

	modport source (output valid, output worker, output start_time, input ready);
	modport sink (input valid, input worker, input start_time, output ready);
endinterface

`default_nettype wire

// ===== rtl/efws_cfg_if.sv =====
// Configuration write channel: valid/ready handshake carrying the worker count.
// Depends on efws_pkg.
`default_nettype none

interface efws_cfg_if;
	import efws_pkg::*;

	logic               valid;
	logic               ready;
	logic [COUNT_W-1:0] worker_count;

	modport source (output valid, output worker_count, input ready);
	modport sink (input valid, input worker_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/efws_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module efws_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/efws_ctrl.sv =====
// Scan and update sequencer: clears the free-time RAM after reset, scans the
// active workers for the earliest free time, then writes back the new time.
// Depends on efws_pkg, efws_job_if.
`default_nettype none

module efws_ctrl #(
	parameter int MAX_WORKERS = 64,
	parameter int TIME_WIDTH  = 48,
	localparam int IDX_W = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1,
	localparam int CNT_W = $clog2(MAX_WORKERS + 1)
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	efws_job_if.sink                           job,
	input  wire logic [efws_pkg::COUNT_W-1:0]  worker_count,
	input  wire logic                          slot_free,
	output logic                               push,
	output efws_pkg::sched_result_t            res,
	output logic                               ram_we,
	output logic      [IDX_W-1:0]              ram_waddr,
	output logic      [TIME_WIDTH-1:0]         ram_wdata,
	output logic                               ram_re,
	output logic      [IDX_W-1:0]              ram_raddr,
	input  wire logic [TIME_WIDTH-1:0]         ram_rdata
);
	import efws_pkg::*;

	localparam int SUM_W = TIME_WIDTH + 1;

	sched_state_t              state_q, state_d;
	logic [IDX_W-1:0]          clr_q;
	logic [CNT_W-1:0]          rd_ptr_q;
	logic [IDX_W-1:0]          cmp_idx_q;
	logic [CNT_W-1:0]          n_q;
	logic [DURATION_W-1:0]     dur_q;
	logic [TIME_WIDTH-1:0]     best_time_q;
	logic [IDX_W-1:0]          best_idx_q;

	logic [CNT_W-1:0]          n_active;
	logic                      better;
	logic                      last_cmp;
	logic [SUM_W-1:0]          sum;
	logic [TIME_WIDTH-1:0]     sat_time;
	logic [31:0]               idx_ext;
	logic [63:0]               time_ext;

	// Zero counts as one worker; counts above the array size clamp to it.
	always_comb begin
		if (worker_count == '0) begin
			n_active = CNT_W'(1);
		end else if (32'(worker_count) > MAX_WORKERS) begin
			n_active = CNT_W'(MAX_WORKERS);
		end else begin
			n_active = CNT_W'(worker_count);
		end
	end

	assign better   = (cmp_idx_q == '0) || (ram_rdata < best_time_q);
	assign last_cmp = (CNT_W'(cmp_idx_q) == (n_q - CNT_W'(1)));
	assign sum      = {1'b0, best_time_q} + SUM_W'(dur_q);
	assign sat_time = sum[TIME_WIDTH] ? '1 : sum[TIME_WIDTH-1:0];

	assign idx_ext        = 32'(best_idx_q);
	assign time_ext       = 64'(best_time_q);
	assign res.worker     = idx_ext[WORKER_W-1:0];
	assign res.start_time = time_ext[START_W-1:0];

	always_comb begin
		state_d   = state_q;
		job.ready = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = best_idx_q;
		ram_wdata = sat_time;
		ram_re    = 1'b0;
		ram_raddr = rd_ptr_q[IDX_W-1:0];
		push      = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
				if (clr_q == IDX_W'(MAX_WORKERS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				job.ready = 1'b1;
				if (job.valid) begin
					ram_re    = 1'b1;
					ram_raddr = '0;
					state_d   = ST_SCAN;
				end
			end
			ST_SCAN: begin
				ram_re = (rd_ptr_q < n_q);
				if (last_cmp) begin
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: begin
				// hold the write-back until the result register can take it
				if (slot_free) begin
					ram_we  = 1'b1;
					push    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			rd_ptr_q  <= '0;
			cmp_idx_q <= '0;
			n_q       <= CNT_W'(1);
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + IDX_W'(1);
			end
			if (state_q == ST_IDLE && job.valid) begin
				n_q       <= n_active;
				rd_ptr_q  <= CNT_W'(1);
				cmp_idx_q <= '0;
			end
			if (state_q == ST_SCAN) begin
				rd_ptr_q  <= rd_ptr_q + CNT_W'(1);
				cmp_idx_q <= cmp_idx_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && job.valid) begin
			dur_q <= job.duration;
		end
		if (state_q == ST_SCAN && better) begin
			best_time_q <= ram_rdata;
			best_idx_q  <= cmp_idx_q;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/earliest_free_worker_scheduler.sv =====
// Earliest-free-worker scheduler, top level: worker count register, free-time
// RAM, scan sequencer and result register. Depends on efws_pkg, the channel
// interfaces, efws_ram and efws_ctrl.
//
// Each job transaction carries a duration. The block assigns it to the active
// worker whose free time is smallest, ties going to the lowest index, returns
// that worker and its free time as the start time, and advances the worker's
// free time by the duration, saturating at the all-ones time value. Free times
// live in a single RAM of MAX_WORKERS entries. After reset a clearing pass
// writes zero to every entry, during which no job is taken; configuration
// writes are accepted at any time. A job is then handled in steps: accept it
// and issue the first read, stream the free times of the active workers
// through the RAM read port (one entry a cycle) and compare, then write back,
// which waits until the result register is free. The result sits in an output
// register, so the next job can start while the result waits to be taken.
// A worker count of zero acts as one, a count above MAX_WORKERS acts as
// MAX_WORKERS; changing it keeps all free times.
`default_nettype none

module earliest_free_worker_scheduler #(
	parameter int MAX_WORKERS = 64,
	parameter int TIME_WIDTH  = 48
) (
	input wire logic   clk,
	input wire logic   arst_n,
	efws_cfg_if.sink   cfg,
	efws_job_if.sink   job,
	efws_result_if.source result
);
	import efws_pkg::*;

	localparam int IDX_W = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;

	logic [COUNT_W-1:0]    worker_count_q;
	logic                  res_valid_q;
	sched_result_t         res_q;

	logic                  push;
	sched_result_t         res;
	logic                  slot_free;
	logic                  ram_we;
	logic [IDX_W-1:0]      ram_waddr;
	logic [TIME_WIDTH-1:0] ram_wdata;
	logic                  ram_re;
	logic [IDX_W-1:0]      ram_raddr;
	logic [TIME_WIDTH-1:0] ram_rdata;

	// Worker count register: always writable.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			worker_count_q <= COUNT_RESET;
		end else if (cfg.valid) begin
			worker_count_q <= cfg.worker_count;
		end
	end

	efws_ram #(
		.WIDTH (TIME_WIDTH),
		.DEPTH (MAX_WORKERS)
	) u_free_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	efws_ctrl #(
		.MAX_WORKERS (MAX_WORKERS),
		.TIME_WIDTH  (TIME_WIDTH)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.job          (job),
		.worker_count (worker_count_q),
		.slot_free    (slot_free),
		.push         (push),
		.res          (res),
		.ram_we       (ram_we),
		.ram_waddr    (ram_waddr),
		.ram_wdata    (ram_wdata),
		.ram_re       (ram_re),
		.ram_raddr    (ram_raddr),
		.ram_rdata    (ram_rdata)
	);

	// Result register: free when empty or drained this cycle.
	assign slot_free = !res_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (push) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			res_q <= res;
		end
	end

	assign result.valid      = res_valid_q;
	assign result.worker     = res_q.worker;
	assign result.start_time = res_q.start_time;

	// Never overwrite a result that has not been taken.
	a_push_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!res_valid_q || result.ready))
		else $error("result pushed over a pending result");

	// Every result goes out together with its free-time write-back.
	a_push_writes: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> ram_we)
		else $error("result pushed without free-time update");

	// Reads and writes of the free-time RAM never share a cycle.
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("free-time RAM read and written in one cycle");

	// One job at a time: no job is taken in the cycle after an accepted one.
	a_one_job: assert property (@(posedge clk) disable iff (!arst_n)
		(job.valid && job.ready) |=> !job.ready)
		else $error("job accepted while previous job in flight");

endmodule

`default_nettype wire
